### src/olist_pkg.sv
// Shared types and constants for the ordered array list.
package olist_pkg;

  localparam int DATA_W = 32;

  // Configuration register index, taken from paddr[2]
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic [4:0] MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_DUMP   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_EMIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_END
  } olist_state_t;

  typedef struct packed {
    status_t            status;
    logic               reported;
    logic [3:0]         entry_index;
    logic [DATA_W-1:0]  entry_value;
    logic [4:0]         count;
    logic               last;
  } result_t;

endpackage

### src/ordered_array_list.sv
// Top level of the ordered array list: ports, configuration register, result register.
//
// Slave stream (s_*) takes one item per operation: s_tuser carries the op code,
// s_tdata the position and value. Master stream (m_*) gives the results; m_tlast
// marks the final result of an item and m_tuser flags results that carry an
// index and entry.
// Results: one for insert, append, remove and unknown op codes; one per match for
// search and one per entry for dump, or a single non-reporting result when there
// is nothing to report.
// Timing: s_tready is high only while the sequencer is idle. Every entry access
// goes through the single registered read port of the entry store, so each moved
// or scanned entry takes a read state and then a write or compare state.
// The next item can be taken in the cycle after the final result is placed.
// A result waits in the output register; the sequencer keeps working until it
// needs to place the next result and m_tready is still low, then it holds.
// Reset empties the list, sets max_entries to 16 and clears m_tvalid, not the result data;
// the store itself is not cleared, entries above the count are never read.
module ordered_array_list #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: position[4:0], value[36:5], zero pad[39:37]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser: op[2:0]
  input  logic [2:0]  s_tuser,
  // m_tdata: status[1:0], entry_index[5:2], entry_value[37:6], count[42:38], zero pad[47:43]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  // m_tuser: reported[0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import olist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [4:0]        max_entries;
  logic              mem_we, mem_re, push, out_free;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  result_t           res, out_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? 32'(max_entries) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_ENTRIES)) begin
      max_entries <= pwdata[4:0];
    end
  end

  olist_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  olist_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_pos      (s_tdata[4:0]),
    .in_val      (s_tdata[36:5]),
    .max_entries (max_entries),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_free    (out_free),
    .push        (push),
    .res         (res)
  );

  // output register: refill as the held result is taken
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res.count, out_res.entry_value, out_res.entry_index,
                    out_res.status};
  assign m_tuser = out_res.reported;
  assign m_tlast = out_res.last;

endmodule

### src/olist_mem.sv
// Entry store: one write port and one read port with registered read data.
module olist_mem #(
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [olist_pkg::DATA_W-1:0]              wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [olist_pkg::DATA_W-1:0]              rdata
);
  import olist_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/olist_ctrl.sv
// Sequencer: checks each operation, walks the store one entry at a time.
module olist_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [2:0]                               in_op,
  input  logic [4:0]                               in_pos,
  input  logic [olist_pkg::DATA_W-1:0]              in_val,
  input  logic [4:0]                               max_entries,
  output logic                                     mem_we,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_waddr,
  output logic [olist_pkg::DATA_W-1:0]              mem_wdata,
  output logic                                     mem_re,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_raddr,
  input  logic [olist_pkg::DATA_W-1:0]              mem_rdata,
  input  logic                                     out_free,
  output logic                                     push,
  output olist_pkg::result_t                       res
);
  import olist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  olist_state_t      state, state_next;
  op_t               op;
  logic [4:0]        pos;
  logic [DATA_W-1:0] val;
  logic [AW-1:0]     idx, idx_next;
  logic [CW-1:0]     fill, fill_next;
  status_t           status, status_next;
  logic              pend_valid, pend_valid_next;
  logic [3:0]        pend_idx, pend_idx_next;
  logic [DATA_W-1:0] pend_val, pend_val_next;

  logic [NW-1:0] fill_n, pos_n, idx_n, cap_n, eff_cap;
  logic          full, idx_last, match, go;

  assign fill_n   = NW'(fill);
  assign pos_n    = NW'(pos);
  assign idx_n    = NW'(idx);
  assign cap_n    = NW'(max_entries);
  assign eff_cap  = (cap_n < NW'(CAPACITY)) ? cap_n : NW'(CAPACITY);
  assign full     = (fill_n >= eff_cap);
  assign idx_last = ((idx_n + NW'(1)) == fill_n);
  // the one comparator, shared by every search scan step
  assign match    = (mem_rdata == val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= op_t'(in_op);
      pos <= in_pos;
      val <= in_val;
    end
    idx      <= idx_next;
    status   <= status_next;
    pend_idx <= pend_idx_next;
    pend_val <= pend_val_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    fill_next       = fill;
    status_next     = status;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    pend_val_next   = pend_val;
    in_ready        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = mem_rdata;
    mem_re          = 1'b0;
    mem_raddr       = idx;
    push            = 1'b0;
    go              = 1'b0;
    res             = '0;
    res.count       = fill_n[4:0];
    res.last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_next     = ST_OK;
          pend_valid_next = 1'b0;
          state_next      = S_CHECK;
        end
      end

      S_CHECK: begin
        unique case (op)
          OP_INSERT: begin
            if (full) begin
              status_next = ST_FULL;
              state_next  = S_EMIT;
            end else if (pos_n > fill_n) begin
              status_next = ST_RANGE;
              state_next  = S_EMIT;
            end else begin
              idx_next   = AW'(fill);
              state_next = (fill_n > pos_n) ? S_SHIFT_RD : S_WRITE;
            end
          end
          OP_APPEND: begin
            if (full) begin
              status_next = ST_FULL;
              state_next  = S_EMIT;
            end else begin
              idx_next   = AW'(fill);
              state_next = S_WRITE;
            end
          end
          OP_REMOVE: begin
            if (fill == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_EMIT;
            end else if (pos_n >= fill_n) begin
              status_next = ST_RANGE;
              state_next  = S_EMIT;
            end else if ((pos_n + NW'(1)) < fill_n) begin
              idx_next   = AW'(pos);
              state_next = S_SHIFT_RD;
            end else begin
              // removing the tail entry: nothing to move
              fill_next  = fill - CW'(1);
              state_next = S_EMIT;
            end
          end
          OP_SEARCH, OP_DUMP: begin
            if (fill == '0) begin
              state_next = S_EMIT;
            end else begin
              idx_next   = '0;
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end

      S_SHIFT_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = (op == OP_INSERT) ? (idx - AW'(1)) : (idx + AW'(1));
        state_next = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_we = 1'b1;
        if (op == OP_INSERT) begin
          idx_next   = idx - AW'(1);
          state_next = ((idx_n - NW'(1)) == pos_n) ? S_WRITE : S_SHIFT_RD;
        end else if ((idx_n + NW'(2)) == fill_n) begin
          fill_next  = fill - CW'(1);
          state_next = S_EMIT;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_SHIFT_RD;
        end
      end

      S_WRITE: begin
        mem_we     = 1'b1;
        mem_wdata  = val;
        fill_next  = fill + CW'(1);
        state_next = S_EMIT;
      end

      S_EMIT: begin
        res.status = status;
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        mem_re     = 1'b1;
        state_next = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (op == OP_DUMP) begin
          res.reported    = 1'b1;
          res.entry_index = idx_n[3:0];
          res.entry_value = mem_rdata;
          res.last        = idx_last;
          push            = out_free;
          go              = out_free;
        end else begin
          // hold each match back until the next one shows whether it is the final one
          res.reported    = 1'b1;
          res.entry_index = pend_idx;
          res.entry_value = pend_val;
          res.last        = 1'b0;
          go              = !(match && pend_valid) || out_free;
          push            = match && pend_valid && out_free;
          if (match && go) begin
            pend_valid_next = 1'b1;
            pend_idx_next   = idx_n[3:0];
            pend_val_next   = mem_rdata;
          end
        end
        if (go) begin
          if (idx_last) begin
            state_next = (op == OP_DUMP) ? S_IDLE : S_SCAN_END;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_SCAN_RD;
          end
        end
      end

      S_SCAN_END: begin
        if (pend_valid) begin
          res.reported    = 1'b1;
          res.entry_index = pend_idx;
          res.entry_value = pend_val;
        end
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/olist_checker.sv
// Port-level checks for the ordered array list, bound to the top level.
module olist_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an accepted item occupies the sequencer for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready held high after accepting an item");

  // a result with no entry is always the only, final one
  a_plain_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("non-reporting result without last");

  // reported entries come only from successful search or dump
  a_reported_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[1:0] == 2'd0)
    else $error("reported result with error status");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

endmodule

bind ordered_array_list olist_checker u_olist_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### verif/ordered_array_list_tb.sv
// Self-checking testbench for ordered_array_list: directed table, random phases, stream checks.
module ordered_array_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  localparam int LIST_CAP = 16;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 45;

  // op codes the block ignores
  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_ONES = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ordered_array_list #(.CAPACITY(LIST_CAP)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the list held by the block
  logic [31:0]  list_mem [LIST_CAP];
  int unsigned  list_fill = 0;
  logic [4:0]   max_entries_q = MAX_ENTRIES_RST;

  result_t op_results [$];
  result_t pending_results [$];
  int      err_count = 0;
  bit      quiet_phase = 1'b0;
  bit      hold_request = 1'b0;
  bit      hold_taken = 1'b0;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;
    bit          typed;
    status_t     st;
    logic [4:0]  cnt;
  } dir_row_t;

  dir_row_t dir_rows [28];

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Work out the results of one item and update the shadow list.
  function automatic void apply_list_op(logic [2:0] op, logic [4:0] pos, logic [31:0] val);
    int unsigned cap;
    int unsigned slot;
    status_t st;
    op_results.delete();
    cap = (max_entries_q > LIST_CAP) ? LIST_CAP : max_entries_q;
    st = ST_OK;
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (list_fill >= cap) begin
          st = ST_FULL;
        end else if (op == OP_INSERT && pos > list_fill) begin
          st = ST_RANGE;
        end else begin
          slot = (op == OP_APPEND) ? list_fill : pos;
          for (int i = list_fill; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = val;
          list_fill++;
        end
      end
      OP_REMOVE: begin
        if (list_fill == 0) begin
          st = ST_EMPTY;
        end else if (pos >= list_fill) begin
          st = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
          list_fill--;
        end
      end
      OP_SEARCH, OP_DUMP: begin
        for (int i = 0; i < list_fill; i++) begin
          if (op == OP_DUMP || list_mem[i] == val)
            op_results.push_back('{ST_OK, 1'b1, 4'(i), list_mem[i], 5'(list_fill), 1'b0});
        end
        if (op_results.size() != 0) op_results[op_results.size()-1].last = 1'b1;
      end
      default: ;
    endcase
    if (op_results.size() == 0)
      op_results.push_back('{st, 1'b0, 4'd0, 32'd0, 5'(list_fill), 1'b1});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_phase || r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(99) < 88) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45 && list_fill != 0) return list_mem[$urandom_range(list_fill - 1)];
    if (r < 70) begin
      case ($urandom_range(4))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_ONES;
        3: return 32'd1;
        default: return 32'd0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_item(logic [2:0] op, logic [4:0] pos, logic [31:0] val, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, val, pos};
    do @(posedge clk); while (!s_tready);
    apply_list_op(op, pos, val);
    foreach (op_results[i]) pending_results.push_back(op_results[i]);
  endtask

  // Drain, write max_entries, then read it back.
  task automatic write_max_entries(logic [31:0] wval);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 || !s_tready) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_MAX_ENTRIES, 2'b00};
    pwdata  <= wval;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1)
      report_error("pready low during a write access");
    max_entries_q = wval[4:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[4:0] !== wval[4:0])
      report_error($sformatf("max_entries read back %0d, wrote %0d", prdata[4:0], wval[4:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : rx_pacing
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        // long hold-off so the block backs up and drops s_tready
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_phase && $urandom_range(99) < 30) begin
        m_tready <= 1'b0;
        repeat (pick_stall()) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : rx_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{status_t'(m_tdata[1:0]), m_tuser, m_tdata[5:2], m_tdata[37:6],
              m_tdata[42:38], m_tlast};
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with nothing expected: %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_error($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.reported !== want.reported)
          report_error($sformatf("reported %0b, expected %0b", got.reported, want.reported));
        if (got.entry_index !== want.entry_index)
          report_error($sformatf("entry_index %0d, expected %0d",
                                 got.entry_index, want.entry_index));
        if (got.entry_value !== want.entry_value)
          report_error($sformatf("entry_value %h, expected %h",
                                 got.entry_value, want.entry_value));
        if (got.count !== want.count)
          report_error($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.last !== want.last)
          report_error($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] phase_caps [PHASES];
    int unsigned op_mix [3][6];
    logic [2:0]  op_codes [6];
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;
    int          r;
    int          acc;
    int          pick;

    dir_rows = '{
      '{0, OP_DUMP,   5'd0,  32'd0,         1, ST_OK,    5'd0},
      '{0, OP_SEARCH, 5'd0,  32'd0,         1, ST_OK,    5'd0},
      '{0, OP_REMOVE, 5'd0,  32'd0,         1, ST_EMPTY, 5'd0},
      '{0, OP_INSERT, 5'd1,  32'd5,         1, ST_RANGE, 5'd0},
      '{0, OP_BAD5,   5'd0,  32'd0,         1, ST_OK,    5'd0},
      '{0, OP_INSERT, 5'd0,  VAL_MIN,       1, ST_OK,    5'd1},
      '{0, OP_APPEND, 5'd0,  VAL_MAX,       1, ST_OK,    5'd2},
      '{0, OP_INSERT, 5'd2,  VAL_ONES,      1, ST_OK,    5'd3},
      '{0, OP_INSERT, 5'd1,  32'd0,         1, ST_OK,    5'd4},
      '{0, OP_APPEND, 5'd0,  VAL_MAX,       1, ST_OK,    5'd5},
      '{0, OP_SEARCH, 5'd0,  VAL_MAX,       0, ST_OK,    5'd0},
      '{0, OP_SEARCH, 5'd0,  32'h1234_5678, 1, ST_OK,    5'd5},
      '{0, OP_DUMP,   5'd0,  32'd0,         0, ST_OK,    5'd0},
      '{0, OP_REMOVE, 5'd5,  32'd0,         1, ST_RANGE, 5'd5},
      '{0, OP_REMOVE, 5'd31, 32'd0,         1, ST_RANGE, 5'd5},
      '{0, OP_INSERT, 5'd31, 32'd9,         1, ST_RANGE, 5'd5},
      '{0, OP_INSERT, 5'd5,  32'h5555_5555, 1, ST_OK,    5'd6},
      '{0, OP_REMOVE, 5'd0,  32'd0,         1, ST_OK,    5'd5},
      '{0, OP_REMOVE, 5'd4,  32'd0,         1, ST_OK,    5'd4},
      '{0, OP_BAD7,   5'd0,  32'd0,         1, ST_OK,    5'd4},
      '{1, OP_DUMP,   5'd0,  32'd4,         0, ST_OK,    5'd0},
      '{0, OP_APPEND, 5'd0,  32'hAAAA_AAAA, 1, ST_FULL,  5'd4},
      '{0, OP_INSERT, 5'd0,  32'd3,         1, ST_FULL,  5'd4},
      '{1, OP_DUMP,   5'd0,  32'd0,         0, ST_OK,    5'd0},
      '{0, OP_INSERT, 5'd0,  32'd7,         1, ST_FULL,  5'd4},
      '{0, OP_REMOVE, 5'd0,  32'd0,         1, ST_OK,    5'd3},
      '{0, OP_DUMP,   5'd0,  32'd0,         0, ST_OK,    5'd0},
      '{1, OP_DUMP,   5'd0,  VAL_ONES,      0, ST_OK,    5'd0}
    };
    phase_caps = '{32'd16, 32'd1, VAL_ONES, 32'd8, 32'd0,
                   32'd16, 32'd2, 32'd20, 32'd12, 32'd16};
    // weights: insert, append, remove, search, dump, unknown; rows grow, mixed, shrink
    op_mix = '{'{35, 30, 10, 12, 8, 5}, '{25, 15, 25, 17, 13, 5}, '{12, 8, 50, 15, 10, 5}};
    op_codes = '{OP_INSERT, OP_APPEND, OP_REMOVE, OP_SEARCH, OP_DUMP, OP_BAD5};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        write_max_entries(dir_rows[k].val);
      end else begin
        send_item(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].val, pick_gap());
        if (dir_rows[k].typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back('{dir_rows[k].st, 1'b0, 4'd0, 32'd0, dir_rows[k].cnt, 1'b1});
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_max_entries(phase_caps[ph]);
      quiet_phase = (ph == 2 || ph == 6);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 5) hold_request = 1'b1;
        r = $urandom_range(99);
        acc = 0;
        pick = 5;
        for (int j = 0; j < 6; j++) begin
          acc += op_mix[ph % 3][j];
          if (r < acc) begin
            pick = j;
            break;
          end
        end
        op = op_codes[pick];
        if (op == OP_BAD5) op = op + 3'($urandom_range(2));
        if ($urandom_range(99) < 20) pos = 5'($urandom_range(31));
        else if (op == OP_REMOVE)
          pos = (list_fill == 0) ? 5'd0 : 5'($urandom_range(list_fill - 1));
        else pos = 5'($urandom_range(list_fill));
        val = pick_value();
        send_item(op, pos, val, pick_gap());
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("ordered_array_list_tb: done, clean");
    end else begin
      $display("ordered_array_list_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("ordered_array_list_tb: done, errors");
    $finish;
  end

endmodule
